// File: rtl/mdsl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdsl_pkg
// shared widths, register map and link types of the median speed limiter
// ---------------------------------------------------------------------------
package mdsl_pkg;

	localparam int WINDOW  = 7;
	localparam int MID     = WINDOW / 2;
	localparam int DIST_W  = 8;
	localparam int SPEED_W = 7;
	localparam int VEL_W   = 8;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
	localparam logic [1:0] REG_SLOW_MARGIN   = 2'd1;
	localparam logic [1:0] REG_NORMAL_MARGIN = 2'd2;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 7'd60;
	localparam logic [DIST_W-1:0]  SLOW_MARGIN_RST   = 8'd20;
	localparam logic [DIST_W-1:0]  NORMAL_MARGIN_RST = 8'd40;

	// what one cell hands to the next one down the row
	typedef struct packed {
		logic              keep;
		logic              valid;
		logic [DIST_W-1:0] value;
	} link_t;

	typedef struct packed {
		logic reverse;
		logic slow_mode;
		logic hold;
		logic avoid_enable;
	} mode_t;

	typedef struct packed {
		logic [SPEED_W-1:0] max_speed;
		logic [DIST_W-1:0]  slow_margin;
		logic [DIST_W-1:0]  normal_margin;
	} cfg_t;

endpackage

// File: rtl/mdsl_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdsl_cell
// one slot of the sorted insertion row, kept in descending order
// ---------------------------------------------------------------------------
module mdsl_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        insert,
	input  logic                        clear,
	input  logic [mdsl_pkg::DIST_W-1:0] sample,
	input  mdsl_pkg::link_t             prev,
	output mdsl_pkg::link_t             link,
	output logic [mdsl_pkg::DIST_W-1:0] next_value
);

	logic                        valid_q;
	logic [mdsl_pkg::DIST_W-1:0] value_q;
	logic                        keep;
	logic                        next_valid;

	assign keep = valid_q && (value_q >= sample);

	always_comb begin
		if (keep) begin
			next_value = value_q;
			next_valid = 1'b1;
		end else if (prev.keep) begin
			next_value = sample;
			next_valid = 1'b1;
		end else begin
			next_value = prev.value;
			next_valid = prev.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (insert) begin
			valid_q <= next_valid && !clear;
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			value_q <= next_value;
		end
	end

	assign link.keep  = keep;
	assign link.valid = valid_q;
	assign link.value = value_q;

endmodule

// File: rtl/mdsl_speed.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdsl_speed
// velocity stage and output register of the median speed limiter
// ---------------------------------------------------------------------------
module mdsl_speed (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mdsl_pkg::DIST_W-1:0] median,
	input  mdsl_pkg::mode_t             mode,
	input  mdsl_pkg::cfg_t              cfg,
	output logic                        busy,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata
);

	logic                         s1_valid_q;
	logic [mdsl_pkg::DIST_W-1:0]  median_s1;
	mdsl_pkg::mode_t              mode_s1;
	logic                         out_valid_q;
	logic [mdsl_pkg::VEL_W-1:0]   velocity_q;
	logic [mdsl_pkg::DIST_W-1:0]  median_q;
	logic                         move;
	logic [mdsl_pkg::DIST_W-1:0]  margin;
	logic [mdsl_pkg::DIST_W-1:0]  diff;
	logic [mdsl_pkg::SPEED_W-1:0] clamped;
	logic [mdsl_pkg::SPEED_W-1:0] mag;
	logic [mdsl_pkg::SPEED_W-1:0] mag_h;
	logic [mdsl_pkg::VEL_W-1:0]   velocity;

	assign move = s1_valid_q && (!out_valid_q || m_tready);

	always_comb begin
		margin  = mode_s1.slow_mode ? cfg.slow_margin : cfg.normal_margin;
		diff    = (median_s1 > margin) ? median_s1 - margin : '0;
		clamped = (diff > {1'b0, cfg.max_speed}) ? cfg.max_speed
			: diff[mdsl_pkg::SPEED_W-1:0];
		mag     = (mode_s1.reverse && mode_s1.avoid_enable) ? clamped : cfg.max_speed;
		mag_h   = mode_s1.slow_mode ? (mag >> 1) : mag;
		if (mode_s1.hold) begin
			velocity = '0;
		end else if (mode_s1.reverse) begin
			velocity = -{1'b0, mag_h};
		end else begin
			velocity = {1'b0, mag_h};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				s1_valid_q <= 1'b1;
			end else if (move) begin
				s1_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			median_s1 <= median;
			mode_s1   <= mode;
		end
		if (move) begin
			velocity_q <= velocity;
			median_q   <= median_s1;
		end
	end

	assign busy     = s1_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {median_q, velocity_q};

endmodule

// File: rtl/median_distance_speed_limiter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_distance_speed_limiter
// median of seven distance samples and reverse speed clamp
// ---------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         one distance sample with its mode flags
// m_*       out        velocity and median, one item per group of seven
// apb       in/out     max_speed 0x0, slow_margin 0x4, normal_margin 0x8
//
// a sample is taken every cycle unless the velocity stage is busy; a sorted row
// of seven cells inserts it at once; after the seventh sample of a group the
// input stalls while the velocity stage holds that group; m_tvalid rises once the
// group has moved from the velocity stage into the output register
// a stalled output holds the velocity stage, which then holds the input
// reset empties the row and loads the register defaults
// ---------------------------------------------------------------------------
module median_distance_speed_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // distance, reverse, slow_mode, hold, avoid_enable
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // velocity, median_distance
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdsl_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int W = mdsl_pkg::WINDOW;

	mdsl_pkg::cfg_t              cfg_q;
	mdsl_pkg::mode_t             mode;
	mdsl_pkg::link_t             links [W+1];
	logic [mdsl_pkg::DIST_W-1:0] next_vals [W];
	logic [W-1:0]                valids;
	logic [mdsl_pkg::DIST_W-1:0] sample;
	logic                        accept;
	logic                        last;
	logic                        busy;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed     <= mdsl_pkg::MAX_SPEED_RST;
			cfg_q.slow_margin   <= mdsl_pkg::SLOW_MARGIN_RST;
			cfg_q.normal_margin <= mdsl_pkg::NORMAL_MARGIN_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				mdsl_pkg::REG_MAX_SPEED:     cfg_q.max_speed     <= pwdata[6:0];
				mdsl_pkg::REG_SLOW_MARGIN:   cfg_q.slow_margin   <= pwdata[7:0];
				mdsl_pkg::REG_NORMAL_MARGIN: cfg_q.normal_margin <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mdsl_pkg::REG_MAX_SPEED:     prdata = {25'd0, cfg_q.max_speed};
			mdsl_pkg::REG_SLOW_MARGIN:   prdata = {24'd0, cfg_q.slow_margin};
			mdsl_pkg::REG_NORMAL_MARGIN: prdata = {24'd0, cfg_q.normal_margin};
			default:                     prdata = '0;
		endcase
	end

	assign sample            = s_tdata[7:0];
	assign mode.reverse      = s_tdata[8];
	assign mode.slow_mode    = s_tdata[9];
	assign mode.hold         = s_tdata[10];
	assign mode.avoid_enable = s_tdata[11];

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	// the group is complete when this sample fills the last empty cell
	assign last     = valids[W-2];

	// head of the row always lets a new sample in
	assign links[0].keep  = 1'b1;
	assign links[0].valid = 1'b0;
	assign links[0].value = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		mdsl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.insert     (accept),
			.clear      (last),
			.sample     (sample),
			.prev       (links[i]),
			.link       (links[i+1]),
			.next_value (next_vals[i])
		);
		assign valids[i] = links[i+1].valid;
	end

	mdsl_speed u_speed (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && last),
		.median   (next_vals[mdsl_pkg::MID]),
		.mode     (mode),
		.cfg      (cfg_q),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// cells fill from the head, so the valid bits form a thermometer
	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((valids >> 1) & ~valids) == '0)
		else $error("cell row has a gap");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> valids == '0)
		else $error("row not emptied after a full group");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> busy && !s_tready)
		else $error("velocity stage not loaded after a full group");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> valids != '0)
		else $error("sample lost in cell row");

endmodule

// File: tb/median_distance_speed_limiter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_distance_speed_limiter_tb
// self-checking bench for the median speed limiter: directed groups of
// seven samples, then random streams under several register settings, with
// random gaps on both stream sides and one long output stall; a scoreboard
// predicts velocity and median for every finished group
// ---------------------------------------------------------------------------
module median_distance_speed_limiter_tb;

	localparam int          CLK_HALF     = 5;
	localparam int          IDLE_LIMIT   = 5000;
	localparam int          LATENCY      = 8;
	localparam int          PHASES       = 7;
	localparam int          PHASE_ITEMS  = 218;
	localparam int          HOLDOFF_AT   = 60;
	localparam int          HOLDOFF_LEN  = 400;
	localparam logic [1:0]  REG_UNUSED   = 2'd3;

	class speed_scoreboard;
		logic [mdsl_pkg::SPEED_W-1:0] max_speed;
		logic [mdsl_pkg::DIST_W-1:0]  slow_margin;
		logic [mdsl_pkg::DIST_W-1:0]  normal_margin;
		logic [mdsl_pkg::DIST_W-1:0]  samples[mdsl_pkg::WINDOW];
		int                           count;
		logic [15:0]                  expected_q[$];
		int                           errors;
		int                           results;
		int                           inputs;

		function new();
			max_speed     = mdsl_pkg::MAX_SPEED_RST;
			slow_margin   = mdsl_pkg::SLOW_MARGIN_RST;
			normal_margin = mdsl_pkg::NORMAL_MARGIN_RST;
			foreach (samples[i])
				samples[i] = '0;
			count   = 0;
			errors  = 0;
			results = 0;
			inputs  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				mdsl_pkg::REG_MAX_SPEED:     max_speed = value[mdsl_pkg::SPEED_W-1:0];
				mdsl_pkg::REG_SLOW_MARGIN:   slow_margin = value[mdsl_pkg::DIST_W-1:0];
				mdsl_pkg::REG_NORMAL_MARGIN: normal_margin = value[mdsl_pkg::DIST_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [mdsl_pkg::DIST_W-1:0] group_median();
			logic [mdsl_pkg::DIST_W-1:0] v[mdsl_pkg::WINDOW];
			logic [mdsl_pkg::DIST_W-1:0] t;
			v = samples;
			for (int i = 0; i < mdsl_pkg::WINDOW; i++)
				for (int j = i + 1; j < mdsl_pkg::WINDOW; j++)
					if (v[i] < v[j]) begin
						t = v[i];
						v[i] = v[j];
						v[j] = t;
					end
			return v[mdsl_pkg::MID];
		endfunction

		// item: distance [7:0], reverse [8], slow_mode [9], hold [10], avoid_enable [11]
		function void note_sample(logic [15:0] item);
			logic [mdsl_pkg::DIST_W-1:0] med;
			logic [mdsl_pkg::DIST_W-1:0] margin;
			int                          mag;
			int                          vel;
			inputs++;
			samples[count] = item[7:0];
			count++;
			if (count < mdsl_pkg::WINDOW)
				return;
			count = 0;
			med = group_median();
			if (item[10]) begin
				vel = 0;
			end else begin
				if (item[8] && item[11]) begin
					margin = item[9] ? slow_margin : normal_margin;
					mag = (med > margin) ? int'(med) - int'(margin) : 0;
					if (mag > int'(max_speed))
						mag = int'(max_speed);
				end else begin
					mag = int'(max_speed);
				end
				if (item[9])
					mag = mag / 2;
				vel = item[8] ? -mag : mag;
			end
			expected_q.push_back({med, vel[7:0]});
		endfunction

		// result: velocity [7:0], median_distance [15:8]
		function void check_result(logic [15:0] data);
			logic [15:0] exp_word;
			results++;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual velocity %0d median %0d",
					$time, $signed(data[7:0]), data[15:8]);
				errors++;
				return;
			end
			exp_word = expected_q.pop_front();
			if (data[7:0] !== exp_word[7:0]) begin
				$display("%0t velocity mismatch: expected %0d actual %0d",
					$time, $signed(exp_word[7:0]), $signed(data[7:0]));
				errors++;
			end
			if (data[15:8] !== exp_word[15:8]) begin
				$display("%0t median mismatch: expected %0d actual %0d",
					$time, exp_word[15:8], data[15:8]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata = '0;  // distance, reverse, slow_mode, hold, avoid_enable
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [15:0]                   m_tdata;       // velocity, median_distance
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [mdsl_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	speed_scoreboard sb = new();
	int              tx_mode = 0;
	int              rx_mode = 0;
	int              idle_cycles = 0;
	int              settings = 1;

	median_distance_speed_limiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int draw_gap(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 15);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		endcase
	endfunction

	// inputs and outputs settle between edges, so handshakes are read mid-cycle
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_sample(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// valid stays up after the accepting edge; the next gap or wait_idle drops it
	task automatic send_sample(input logic [15:0] item);
		int gap;
		gap = draw_gap(tx_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// seven samples with a stepped distance; only the last item's flags decide
	task automatic send_group(input logic [7:0] first, input logic [7:0] step,
			input logic [3:0] flags);
		logic [7:0] d;
		d = first;
		for (int i = 0; i < mdsl_pkg::WINDOW; i++) begin
			if (i == mdsl_pkg::WINDOW - 1)
				send_sample({4'b0, flags, d});
			else
				send_sample({4'b0, 4'($urandom_range(0, 15)), d});
			d = d + step;
		end
	endtask

	function automatic logic [15:0] random_sample();
		logic [7:0] d;
		logic [3:0] f;
		case ($urandom_range(0, 3))
			0: d = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			1: d = 8'($urandom_range(0, 127));
			default: d = 8'($urandom_range(0, 255));
		endcase
		f[0] = 1'($urandom_range(0, 1));
		f[1] = 1'($urandom_range(0, 1));
		f[2] = ($urandom_range(0, 3) == 0);
		f[3] = 1'($urandom_range(0, 1));
		return {4'b0, f, d};
	endfunction

	// output side, with one long stall so the velocity stage fills and the input backs up
	initial begin
		int  gap;
		bit  held;
		held = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sb.results >= HOLDOFF_AT) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLDOFF_LEN) @(posedge clk);
			end else begin
				gap = draw_gap(rx_mode);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	initial begin
		logic [31:0] cfg[3];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: clamp to max, below margin, hold, forward slow
		tx_mode = 2;
		rx_mode = 2;
		send_group(8'd255, 8'd0, 4'b1001);
		send_group(8'd0, 8'd0, 4'b1011);
		send_group(8'd37, 8'd73, 4'b0100);
		send_group(8'd200, 8'd9, 4'b0010);

		for (int p = 1; p <= PHASES; p++) begin
			wait_idle();
			case (p)
				1: cfg = '{32'd127, 32'd255, 32'd255};
				2: cfg = '{32'd0, 32'd0, 32'd0};
				3: cfg = '{32'd100, 32'd0, 32'd255};
				default: cfg = '{$urandom_range(0, 127), $urandom_range(0, 255),
					$urandom_range(0, 255)};
			endcase
			if (p == 4)
				apb_write(REG_UNUSED, $urandom());
			apb_write(mdsl_pkg::REG_MAX_SPEED, cfg[0]);
			apb_write(mdsl_pkg::REG_SLOW_MARGIN, cfg[1]);
			apb_write(mdsl_pkg::REG_NORMAL_MARGIN, cfg[2]);
			apb_idle();
			settings++;
			tx_mode = p % 3;
			rx_mode = (p + 1) % 3;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_sample(random_sample());
		end

		wait_idle();
		if (sb.pending() != 0) begin
			$display("%0t %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("run covered %0d samples and %0d results under %0d register settings",
			sb.inputs, sb.results, settings);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/mdsl_pkg.sv
rtl/mdsl_cell.sv
rtl/mdsl_speed.sv
rtl/median_distance_speed_limiter.sv
tb/median_distance_speed_limiter_tb.sv
